// File: hdl/ssq_pkg.sv
// ============================================================================
// ssq_pkg: shared types for the stable sorted priority queue
// Record layout, result status codes and controller/datapath interface.
// ============================================================================
package ssq_pkg;

    // Request kinds carried on s_tuser
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int REC_W  = 56;
    localparam int FILL_W = 8;

    // Packed so that entry_time sits in the lowest bits
    typedef struct packed {
        logic [15:0] life_span;
        logic [7:0]  kind_code;
        logic [7:0]  dropoff_place;
        logic [7:0]  pickup_place;
        logic [15:0] entry_time;
    } rec_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;      // capture request, hole pointer := tail
        logic start_enq;    // read entry just before the tail
        logic scan_shift;   // move read entry up one slot, read the next lower one
        logic place;        // write new record into the hole, count up
        logic deq_read;     // read the head entry
        logic deq_pop;      // take head entry as result, count down
        logic refuse_full;
        logic refuse_empty;
        logic emit;         // load the output register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_deq;
        logic full;
        logic empty;
        logic one_left;     // the read entry is the head entry, the last one left to compare
        logic shift_needed; // read entry is later than the new record
        logic out_free;
    } ctl_sts_t;

endpackage

// File: hdl/ssq_ctrl.sv
// ============================================================================
// ssq_ctrl: request sequencer
// Steps one request at a time through decode, insertion scan or pop, result.
// ============================================================================
module ssq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ssq_pkg::ctl_sts_t sts,
    output ssq_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PLACE,
        S_DEQ_WAIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    // no request is taken while reset is held
    assign s_tready = aresetn && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.is_deq) begin
                    if (sts.empty) begin
                        cmd.refuse_empty = 1'b1;
                        state_next       = S_RESULT;
                    end else begin
                        cmd.deq_read = 1'b1;
                        state_next   = S_DEQ_WAIT;
                    end
                end else if (sts.full) begin
                    cmd.refuse_full = 1'b1;
                    state_next      = S_RESULT;
                end else if (sts.empty) begin
                    cmd.place  = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    cmd.start_enq = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.shift_needed) begin
                    cmd.scan_shift = 1'b1;
                    if (sts.one_left) begin
                        state_next = S_PLACE;
                    end
                end else begin
                    cmd.place  = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = S_RESULT;
            end
            S_DEQ_WAIT: begin
                cmd.deq_pop = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/ssq_datapath.sv
// ============================================================================
// ssq_datapath: circular record store, pointers and result register
// Sorted records live in a ring between head and tail; inserts shift upward.
// ============================================================================
module ssq_datapath #(
    parameter int CAPACITY = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ssq_pkg::REC_W-1:0]   in_rec,
    input  logic                        in_cmd,
    input  ssq_pkg::ctl_cmd_t           cmd,
    output ssq_pkg::ctl_sts_t           sts,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [63:0]                 m_tdata,
    output logic [1:0]                  m_tuser
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    ssq_pkg::rec_t mem [CAPACITY];

    logic [AW-1:0]       head_reg, tail_reg, wptr_reg, rptr_reg;
    logic [CW-1:0]       count_reg, rem_reg;
    logic                cmd_reg;
    ssq_pkg::rec_t       new_reg, rd_reg, res_rec_reg;
    ssq_pkg::status_t    res_status_reg;
    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic [AW-1:0]       raddr, tail_dec, rptr_dec, head_inc, tail_inc;
    logic                rd_en, wr_en;
    ssq_pkg::rec_t       wdata;

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    assign tail_dec = ring_dec(tail_reg);
    assign rptr_dec = ring_dec(rptr_reg);
    assign head_inc = ring_inc(head_reg);
    assign tail_inc = ring_inc(tail_reg);

    assign rd_en = cmd.deq_read | cmd.start_enq | cmd.scan_shift;
    assign raddr = cmd.deq_read  ? head_reg :
                   cmd.start_enq ? tail_dec : rptr_dec;
    assign wr_en = cmd.scan_shift | cmd.place;
    assign wdata = cmd.scan_shift ? rd_reg : new_reg;

    // Store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[raddr];
        end
    end

    assign sts.is_deq       = (cmd_reg == ssq_pkg::CMD_DEQ);
    assign sts.full         = (count_reg == CW'(CAPACITY));
    assign sts.empty        = (count_reg == '0);
    assign sts.one_left     = (rem_reg == CW'(1));
    assign sts.shift_needed = (rd_reg.entry_time > new_reg.entry_time);
    assign sts.out_free     = !m_tvalid_reg || m_tready;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.place) begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + CW'(1);
            end else if (cmd.deq_pop) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan pointers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg  <= in_cmd;
            new_reg  <= in_rec;
            wptr_reg <= tail_reg;
        end
        if (cmd.start_enq) begin
            rptr_reg <= tail_dec;
            rem_reg  <= count_reg;
        end else if (cmd.scan_shift) begin
            wptr_reg <= rptr_reg;
            rptr_reg <= rptr_dec;
            rem_reg  <= rem_reg - CW'(1);
        end
        if (cmd.place) begin
            res_status_reg <= ssq_pkg::ST_DONE;
            res_rec_reg    <= '0;
        end else if (cmd.deq_pop) begin
            res_status_reg <= ssq_pkg::ST_DONE;
            res_rec_reg    <= rd_reg;
        end else if (cmd.refuse_full) begin
            res_status_reg <= ssq_pkg::ST_FULL;
            res_rec_reg    <= '0;
        end else if (cmd.refuse_empty) begin
            res_status_reg <= ssq_pkg::ST_EMPTY;
            res_rec_reg    <= '0;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {ssq_pkg::FILL_W'(count_reg), res_rec_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hdl/stable_sorted_priority_queue_top.sv
// ============================================================================
// stable_sorted_priority_queue_top: stable sorted priority queue of records
// Holds up to CAPACITY records ordered by entry time, ties in arrival order.
// ============================================================================
//
//  channel  dir  tdata (low bit up)                         tuser
//  -------  ---  -----------------------------------------  ----------
//  s_       in   entry_time, pickup, dropoff, kind, span    cmd
//  m_       out  time, pickup, dropoff, kind, span, fill    status
//
//  One request at a time. A refused request or an enqueue into an empty
//  queue goes straight to the result, a dequeue reads and pops the head,
//  and any other enqueue first runs the insertion scan, which moves each of
//  the k held records later than the new one (k = count when it goes to the
//  front) up a slot: one store read and one store write per cycle, one
//  record moved up a slot each cycle. m_tvalid then rises with the result.
//  Reset (aresetn low, synchronous) empties the queue and holds s_tready low;
//  no clearing pass.
//  A result waits in the output register while m_tready is low; the next
//  request can be accepted once the previous result is loaded there.
//
module stable_sorted_priority_queue_top #(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry_time[15:0], pickup_place[23:16],
                                   // dropoff_place[31:24], kind_code[39:32],
                                   // life_span[55:40]
    input  logic [0:0]  s_tuser,   // cmd[0]: 0 enqueue, 1 dequeue
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_time[15:0], out_pickup[23:16],
                                   // out_dropoff[31:24], out_kind[39:32],
                                   // out_span[55:40], fill_count[63:56]
    output logic [1:0]  m_tuser    // status[1:0]: 0 done, 1 full, 2 empty
);

    ssq_pkg::ctl_cmd_t cmd;
    ssq_pkg::ctl_sts_t sts;

    // Sequencer: decides per cycle what the datapath does
    ssq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Ring store, insertion pointers, result/output registers
    ssq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_rec   (s_tdata),
        .in_cmd   (s_tuser[0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/ssq_checker.sv
// ============================================================================
// ssq_checker: port-level checks for the priority queue
// Watches the request and result channels of the top level.
// ============================================================================
module ssq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only one request at work: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is at work");

    // Refused requests carry an all-zero record (enqueue results are zero too, unchecked here)
    a_zero_record: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ssq_pkg::ST_DONE) |-> (m_tdata[55:0] == 56'd0))
        else $error("refused result carries record data");

    // Refused empty means nothing is held
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ssq_pkg::ST_EMPTY) |-> (m_tdata[63:56] == 8'd0))
        else $error("empty refusal with nonzero fill count");

    // No result comes out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stable_sorted_priority_queue_top ssq_checker u_ssq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
